// File: hdl/whsm_pkg.sv
// shared widths, types and defaults for the height statistics merge block
package whsm_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int GAP_W     = 31;
    localparam logic [GAP_W-1:0] GAP_RESET = 31'd65536;

    localparam int NUM_W     = 112;
    localparam int DEN_W     = 96;
    localparam int STEP_W    = 8;
    localparam int QUO_W     = 64;
    localparam int MUL_A_W   = 64;
    localparam int MUL_B_W   = 48;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int SQ_W      = 64;
    localparam int RT_W      = 32;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] value;
    } sqrt_req_t;

    typedef struct packed {
        logic            done;
        logic [RT_W-1:0] root;
    } sqrt_rsp_t;

endpackage

// File: hdl/weighted_height_stats_merge_top.sv
// top level: patch store, merge test and serial statistics sequencer
//
// input channel s_*: one patch item per handshake, s_tuser is the mode
// (0 load, 1 merge). result channel m_*: one item per input item, m_tuser
// is the merged flag, m_tdata the mean, deviation and stored span.
// cfg_*: write of the merge gap, taken in any cycle; write it only while
// no item is in flight.
// the block works on one item at a time. a rejected merge goes straight to
// the output step with no recompute. a load or merge runs the recompute
// sequence on one shared serial divider, multiplier and root unit: a mean
// division unless the weight is zero, then for at most one sample a
// division unless the weight is zero, for several samples up to four
// multiplies and two divisions, and a square root. the divider yields one
// quotient bit per cycle; the input reopens as the result appears.
// a finished result waits in the output register while the next item is
// taken; a new result is held back until that register is free.
// reset clears the stored patch, the mean, the deviation and the gap
// register returns to 1.0 m.
module weighted_height_stats_merge_top #(
    parameter int FRAC_BITS  = whsm_pkg::FRAC_BITS_DEF,
    parameter int COUNT_BITS = whsm_pkg::COUNT_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata, low bit up: add_wsum_z, add_wsum_zz, add_weight, add_count,
    // add_weight_sq, add_low, add_high, zero pad
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [319:0] s_tdata,
    // s_tuser: mode
    input  logic         s_tuser,
    // m_tdata, low bit up: height_mean, height_stdev, span_low, span_high, zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,
    // m_tuser: merged
    output logic         m_tuser,
    // merge gap register
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [whsm_pkg::GAP_W-1:0] cfg_data
);
    localparam int NW = whsm_pkg::NUM_W;
    localparam int DW = whsm_pkg::DEN_W;
    localparam int SW = whsm_pkg::STEP_W;

    localparam logic [63:0] VAR_FLOOR =
        ((64'd1 << (2 * FRAC_BITS)) + 64'd500000) / 64'd1000000;
    localparam logic [47:0] TWO_W       = 48'd1 << (FRAC_BITS + 1);
    localparam logic [32:0] CNT_MAX     = (33'd1 << COUNT_BITS) - 33'd1;
    localparam logic [SW-1:0] MEAN_STEPS = SW'(64 + FRAC_BITS);
    localparam logic [SW-1:0] VAR1_STEPS = SW'(1 + 3 * FRAC_BITS);
    localparam logic [SW-1:0] T1_STEPS   = SW'(NW + 2 * FRAC_BITS);
    localparam logic [SW-1:0] T2_STEPS   = SW'(COUNT_BITS + 3 * FRAC_BITS);

    typedef enum logic [4:0] {
        ST_IDLE, ST_MEAN, ST_MEAN_WAIT, ST_VAR_SEL, ST_VAR1_WAIT, ST_NSQ_WAIT,
        ST_DEN, ST_MM_WAIT, ST_TERM_WAIT, ST_ACC_A, ST_MUL_AN, ST_AN_WAIT,
        ST_T1_WAIT, ST_T2_WAIT, ST_VAR_FIN, ST_SQRT, ST_SQRT_WAIT, ST_OUT
    } state_t;

    state_t state_reg;

    // stored patch
    logic [63:0]           acc_wsum_z_reg;
    logic [63:0]           acc_wsum_zz_reg;
    logic [47:0]           acc_weight_reg;
    logic [COUNT_BITS-1:0] acc_count_reg;
    logic [63:0]           acc_weight_sq_reg;
    logic [31:0]           acc_low_reg;
    logic [31:0]           acc_high_reg;
    logic [31:0]           cur_mean_reg;
    logic [30:0]           cur_stdev_reg;
    logic [whsm_pkg::GAP_W-1:0] gap_reg;
    logic                  merged_reg;

    // recompute temporaries
    logic [63:0]  var_reg;
    logic [DW-1:0] nsq_reg;
    logic [DW-1:0] den_reg;
    logic [whsm_pkg::MUL_P_W-1:0] term_reg;
    logic [63:0]  amag_reg;
    logic [63:0]  t1_reg;
    logic [63:0]  t2_reg;

    // output register
    logic         m_tvalid_reg;
    logic [127:0] m_tdata_reg;
    logic         m_tuser_reg;

    whsm_pkg::div_req_t  div_req_reg;
    whsm_pkg::div_rsp_t  div_rsp;
    whsm_pkg::mul_req_t  mul_req_reg;
    whsm_pkg::mul_rsp_t  mul_rsp;
    whsm_pkg::sqrt_req_t sqrt_req_reg;
    whsm_pkg::sqrt_rsp_t sqrt_rsp;

    // input fields
    logic [63:0] in_wsum_z;
    logic [62:0] in_wsum_zz;
    logic [47:0] in_weight;
    logic [15:0] in_count;
    logic [62:0] in_weight_sq;
    logic [31:0] in_low;
    logic [31:0] in_high;

    assign in_wsum_z    = s_tdata[63:0];
    assign in_wsum_zz   = s_tdata[126:64];
    assign in_weight    = s_tdata[174:127];
    assign in_count     = s_tdata[190:175];
    assign in_weight_sq = s_tdata[253:191];
    assign in_low       = s_tdata[285:254];
    assign in_high      = s_tdata[317:286];

    // count clamped to the stored width
    logic [32:0]           cnt_ext;
    logic [COUNT_BITS-1:0] cnt_in;
    assign cnt_ext = 33'(in_count);
    assign cnt_in  = (cnt_ext > CNT_MAX) ? CNT_MAX[COUNT_BITS-1:0] : cnt_ext[COUNT_BITS-1:0];

    // span overlap test, stored span widened by the gap
    logic signed [33:0] lo_wide;
    logic signed [33:0] hi_wide;
    logic               overlap;
    assign lo_wide = $signed({{2{acc_low_reg[31]}}, acc_low_reg}) - $signed({3'b000, gap_reg});
    assign hi_wide = $signed({{2{acc_high_reg[31]}}, acc_high_reg}) + $signed({3'b000, gap_reg});
    assign overlap = (lo_wide <= $signed({{2{in_high[31]}}, in_high}))
                  && ($signed({{2{in_low[31]}}, in_low}) <= hi_wide);

    // saturating sums
    logic [64:0] sz_sum;
    logic [63:0] sz_sat;
    logic [64:0] szz_sum;
    logic [48:0] sw_sum;
    logic [32:0] sc_sum;
    logic [64:0] swq_sum;
    assign sz_sum  = {acc_wsum_z_reg[63], acc_wsum_z_reg} + {in_wsum_z[63], in_wsum_z};
    assign sz_sat  = (sz_sum[64] != sz_sum[63])
                   ? (sz_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sz_sum[63:0];
    assign szz_sum = {1'b0, acc_wsum_zz_reg} + 65'(in_wsum_zz);
    assign sw_sum  = {1'b0, acc_weight_reg} + {1'b0, in_weight};
    assign sc_sum  = 33'(acc_count_reg) + 33'(cnt_in);
    assign swq_sum = {1'b0, acc_weight_sq_reg} + 65'(in_weight_sq);

    // recompute helpers
    logic [63:0] z_mag;
    logic [31:0] mean_mag;
    logic [63:0] q_mean;
    logic [31:0] mean_clamped;
    logic        w_ge_two;
    logic [47:0] tmag;
    logic [DW-1:0] ns;
    logic [112:0] a_sum;
    logic [63:0]  t_diff;

    assign z_mag    = acc_wsum_z_reg[63] ? (64'd0 - acc_wsum_z_reg) : acc_wsum_z_reg;
    assign mean_mag = cur_mean_reg[31] ? (32'd0 - cur_mean_reg) : cur_mean_reg;
    assign q_mean   = div_rsp.quot;
    assign mean_clamped = acc_wsum_z_reg[63]
        ? ((q_mean >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - q_mean[31:0]))
        : ((q_mean > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_mean[31:0]);
    assign w_ge_two = acc_weight_reg >= TWO_W;
    assign tmag     = w_ge_two ? (acc_weight_reg - TWO_W) : (TWO_W - acc_weight_reg);
    assign ns       = DW'(acc_weight_sq_reg) << FRAC_BITS;
    assign a_sum    = 113'(acc_wsum_zz_reg) + 113'(term_reg);
    assign t_diff   = t1_reg - t2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            acc_wsum_z_reg     <= '0;
            acc_wsum_zz_reg    <= '0;
            acc_weight_reg     <= '0;
            acc_count_reg      <= '0;
            acc_weight_sq_reg  <= '0;
            acc_low_reg        <= '0;
            acc_high_reg       <= '0;
            cur_mean_reg       <= '0;
            cur_stdev_reg      <= '0;
            gap_reg            <= whsm_pkg::GAP_RESET;
            m_tvalid_reg       <= 1'b0;
            div_req_reg.start  <= 1'b0;
            mul_req_reg.start  <= 1'b0;
            sqrt_req_reg.start <= 1'b0;
        end else begin
            div_req_reg.start  <= 1'b0;
            mul_req_reg.start  <= 1'b0;
            sqrt_req_reg.start <= 1'b0;

            if (cfg_valid) begin
                gap_reg <= cfg_data;
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (!s_tuser) begin
                            acc_wsum_z_reg    <= in_wsum_z;
                            acc_wsum_zz_reg   <= 64'(in_wsum_zz);
                            acc_weight_reg    <= in_weight;
                            acc_count_reg     <= cnt_in;
                            acc_weight_sq_reg <= 64'(in_weight_sq);
                            acc_low_reg       <= in_low;
                            acc_high_reg      <= in_high;
                            merged_reg        <= 1'b1;
                            state_reg         <= ST_MEAN;
                        end else if (overlap) begin
                            acc_wsum_z_reg    <= sz_sat;
                            acc_wsum_zz_reg   <= szz_sum[64] ? {64{1'b1}} : szz_sum[63:0];
                            acc_weight_reg    <= sw_sum[48] ? {48{1'b1}} : sw_sum[47:0];
                            acc_count_reg     <= (sc_sum > CNT_MAX)
                                               ? CNT_MAX[COUNT_BITS-1:0]
                                               : sc_sum[COUNT_BITS-1:0];
                            acc_weight_sq_reg <= swq_sum[64] ? {64{1'b1}} : swq_sum[63:0];
                            if ($signed(in_low) < $signed(acc_low_reg)) begin
                                acc_low_reg <= in_low;
                            end
                            if ($signed(in_high) > $signed(acc_high_reg)) begin
                                acc_high_reg <= in_high;
                            end
                            merged_reg <= 1'b1;
                            state_reg  <= ST_MEAN;
                        end else begin
                            // spans apart: stored patch untouched
                            merged_reg <= 1'b0;
                            state_reg  <= ST_OUT;
                        end
                    end
                end
                ST_MEAN: begin
                    if (acc_weight_reg == 48'd0) begin
                        cur_mean_reg <= '0;
                        state_reg    <= ST_VAR_SEL;
                    end else begin
                        div_req_reg.start <= 1'b1;
                        div_req_reg.num   <= {z_mag, 48'd0};
                        div_req_reg.den   <= DW'(acc_weight_reg);
                        div_req_reg.steps <= MEAN_STEPS;
                        state_reg         <= ST_MEAN_WAIT;
                    end
                end
                ST_MEAN_WAIT: begin
                    if (div_rsp.done) begin
                        cur_mean_reg <= mean_clamped;
                        state_reg    <= ST_VAR_SEL;
                    end
                end
                ST_VAR_SEL: begin
                    if (acc_count_reg > COUNT_BITS'(1)) begin
                        mul_req_reg.start <= 1'b1;
                        mul_req_reg.a     <= 64'(acc_weight_reg);
                        mul_req_reg.b     <= acc_weight_reg;
                        state_reg         <= ST_NSQ_WAIT;
                    end else if (acc_weight_reg == 48'd0) begin
                        var_reg   <= VAR_FLOOR;
                        state_reg <= ST_SQRT;
                    end else begin
                        // single sample: 1 / weight
                        div_req_reg.start <= 1'b1;
                        div_req_reg.num   <= {1'b1, {(NW-1){1'b0}}};
                        div_req_reg.den   <= DW'(acc_weight_reg);
                        div_req_reg.steps <= VAR1_STEPS;
                        state_reg         <= ST_VAR1_WAIT;
                    end
                end
                ST_VAR1_WAIT: begin
                    if (div_rsp.done) begin
                        var_reg   <= div_rsp.quot;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_NSQ_WAIT: begin
                    if (mul_rsp.done) begin
                        nsq_reg   <= mul_rsp.prod[DW-1:0];
                        state_reg <= ST_DEN;
                    end
                end
                ST_DEN: begin
                    if (ns >= nsq_reg) begin
                        var_reg   <= VAR_FLOOR;
                        state_reg <= ST_SQRT;
                    end else begin
                        den_reg           <= nsq_reg - ns;
                        mul_req_reg.start <= 1'b1;
                        mul_req_reg.a     <= 64'(mean_mag);
                        mul_req_reg.b     <= 48'(mean_mag);
                        state_reg         <= ST_MM_WAIT;
                    end
                end
                ST_MM_WAIT: begin
                    if (mul_rsp.done) begin
                        mul_req_reg.start <= 1'b1;
                        mul_req_reg.a     <= mul_rsp.prod[63:0];
                        mul_req_reg.b     <= tmag;
                        state_reg         <= ST_TERM_WAIT;
                    end
                end
                ST_TERM_WAIT: begin
                    if (mul_rsp.done) begin
                        term_reg  <= mul_rsp.prod >> (2 * FRAC_BITS);
                        state_reg <= ST_ACC_A;
                    end
                end
                ST_ACC_A: begin
                    if (!w_ge_two) begin
                        amag_reg  <= (|a_sum[112:64]) ? {64{1'b1}} : a_sum[63:0];
                        state_reg <= ST_MUL_AN;
                    end else if (whsm_pkg::MUL_P_W'(acc_wsum_zz_reg) >= term_reg) begin
                        amag_reg  <= acc_wsum_zz_reg - term_reg[63:0];
                        state_reg <= ST_MUL_AN;
                    end else begin
                        var_reg   <= VAR_FLOOR;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_MUL_AN: begin
                    mul_req_reg.start <= 1'b1;
                    mul_req_reg.a     <= amag_reg;
                    mul_req_reg.b     <= acc_weight_reg;
                    state_reg         <= ST_AN_WAIT;
                end
                ST_AN_WAIT: begin
                    if (mul_rsp.done) begin
                        div_req_reg.start <= 1'b1;
                        div_req_reg.num   <= mul_rsp.prod;
                        div_req_reg.den   <= den_reg;
                        div_req_reg.steps <= T1_STEPS;
                        state_reg         <= ST_T1_WAIT;
                    end
                end
                ST_T1_WAIT: begin
                    if (div_rsp.done) begin
                        t1_reg            <= div_rsp.quot;
                        div_req_reg.start <= 1'b1;
                        div_req_reg.num   <= NW'(acc_count_reg) << (NW - COUNT_BITS);
                        div_req_reg.den   <= DW'(acc_weight_reg);
                        div_req_reg.steps <= T2_STEPS;
                        state_reg         <= ST_T2_WAIT;
                    end
                end
                ST_T2_WAIT: begin
                    if (div_rsp.done) begin
                        t2_reg    <= div_rsp.quot;
                        state_reg <= ST_VAR_FIN;
                    end
                end
                ST_VAR_FIN: begin
                    if (t1_reg <= t2_reg || t_diff < VAR_FLOOR) begin
                        var_reg <= VAR_FLOOR;
                    end else begin
                        var_reg <= t_diff;
                    end
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    sqrt_req_reg.start <= 1'b1;
                    sqrt_req_reg.value <= var_reg;
                    state_reg          <= ST_SQRT_WAIT;
                end
                ST_SQRT_WAIT: begin
                    if (sqrt_rsp.done) begin
                        cur_stdev_reg <= sqrt_rsp.root[31] ? {31{1'b1}} : sqrt_rsp.root[30:0];
                        state_reg     <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // wait for the output register to free up
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= merged_reg;
                        m_tdata_reg  <= {1'b0, acc_high_reg, acc_low_reg,
                                         cur_stdev_reg, cur_mean_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    whsm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req_reg),
        .rsp     (div_rsp)
    );

    whsm_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req_reg),
        .rsp     (mul_rsp)
    );

    whsm_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sqrt_req_reg),
        .rsp     (sqrt_rsp)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

endmodule

// File: hdl/whsm_div.sv
// bit-serial restoring divider, one quotient bit per cycle, saturating quotient
module whsm_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  whsm_pkg::div_req_t  req,
    output whsm_pkg::div_rsp_t  rsp
);
    localparam int NW = whsm_pkg::NUM_W;
    localparam int DW = whsm_pkg::DEN_W;
    localparam int QW = whsm_pkg::QUO_W;

    logic                        busy_reg;
    logic                        done_reg;
    logic [whsm_pkg::STEP_W-1:0] cnt_reg;
    logic [NW-1:0]               num_reg;
    logic [DW-1:0]               den_reg;
    logic [DW-1:0]               rem_reg;
    logic [QW-1:0]               quo_reg;
    logic                        sat_reg;

    logic [DW:0] rs;
    logic [DW:0] diff;
    logic        ge;

    assign rs   = {rem_reg, num_reg[NW-1]};
    assign ge   = rs >= {1'b0, den_reg};
    assign diff = rs - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == whsm_pkg::STEP_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
            quo_reg <= '0;
            sat_reg <= 1'b0;
            cnt_reg <= req.steps;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            rem_reg <= ge ? diff[DW-1:0] : rs[DW-1:0];
            sat_reg <= sat_reg | quo_reg[QW-1];
            quo_reg <= {quo_reg[QW-2:0], ge};
            cnt_reg <= cnt_reg - whsm_pkg::STEP_W'(1);
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = sat_reg ? {QW{1'b1}} : quo_reg;

endmodule

// File: hdl/whsm_mul.sv
// shift-add multiplier, one multiplier bit per cycle
module whsm_mul (
    input  logic                aclk,
    input  logic                aresetn,
    input  whsm_pkg::mul_req_t  req,
    output whsm_pkg::mul_rsp_t  rsp
);
    localparam int AW = whsm_pkg::MUL_A_W;
    localparam int BW = whsm_pkg::MUL_B_W;
    localparam int PW = whsm_pkg::MUL_P_W;
    localparam int CW = $clog2(BW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] a_reg;
    logic [BW-1:0] b_reg;
    logic [PW-1:0] p_reg;

    logic [AW:0] sum;

    assign sum = {1'b0, p_reg[PW-1:BW]} + (b_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            p_reg   <= '0;
            cnt_reg <= CW'(BW);
        end else if (busy_reg) begin
            p_reg   <= {sum, p_reg[BW-1:1]};
            b_reg   <= {1'b0, b_reg[BW-1:1]};
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = p_reg;

endmodule

// File: hdl/whsm_sqrt.sv
// digit-by-digit integer square root, one result bit per cycle
module whsm_sqrt (
    input  logic                aclk,
    input  logic                aresetn,
    input  whsm_pkg::sqrt_req_t req,
    output whsm_pkg::sqrt_rsp_t rsp
);
    localparam int VW = whsm_pkg::SQ_W;
    localparam int CW = $clog2(VW / 2 + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [VW-1:0] v_reg;
    logic [VW-1:0] res_reg;
    logic [VW-1:0] bit_reg;

    logic [VW:0] trial;
    logic        ge;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign ge    = {1'b0, v_reg} >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            v_reg   <= req.value;
            res_reg <= '0;
            bit_reg <= VW'(1) << (VW - 2);
            cnt_reg <= CW'(VW / 2);
        end else if (busy_reg) begin
            if (ge) begin
                v_reg   <= v_reg - trial[VW-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = res_reg[whsm_pkg::RT_W-1:0];

endmodule

// File: hdl/whsm_checker.sv
// port-level checks for the height statistics merge block, bound to the top level
module whsm_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tuser
);
    // reset leaves no result pending and the input open
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("state after reset wrong");

    // one item at a time: an accepted item closes the input
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input open right after an accepted item");

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // an idle block with no item offered produces no result
    a_result_needs_work: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && s_tready && !s_tvalid ##1 !s_tvalid |=> !m_tvalid)
        else $error("result appeared without an item");

endmodule

bind weighted_height_stats_merge_top whsm_checker u_whsm_checker (.*);
